>>> rtl/ictf_pkg.sv
// ----------------------------------------------------------------------------
// ictf_pkg
// Shared types and constants of the complementary tilt filter.
// ----------------------------------------------------------------------------
package ictf_pkg;

  localparam int SqrtSteps = 24;
  localparam int StepW     = 5;
  localparam int AtanW     = 27;

  localparam logic [16:0] BlendWeightRst   = 17'd64225;
  localparam logic [16:0] SamplePeriodRst  = 17'd5000;
  localparam logic [16:0] WeightOne        = 17'd65536;
  localparam logic [26:0] GyroDen          = 27'd131000000;
  localparam logic [26:0] GyroHalfDen      = 27'd65500000;

  localparam logic RegBlendWeight  = 1'b0;
  localparam logic RegSamplePeriod = 1'b1;

  typedef struct packed {
    logic             load;
    logic             square;
    logic             setup;
    logic             iter;
    logic             cinit;
    logic             cord;
    logic             round;
    logic             mul;
    logic             commit;
    logic [StepW-1:0] step;
  } ictf_cmd_t;

  function automatic logic [AtanW-1:0] atan_entry(input logic [StepW-1:0] idx);
    logic [AtanW-1:0] v;
    unique case (idx)
      5'd0:    v = 27'd47185920;
      5'd1:    v = 27'd27855475;
      5'd2:    v = 27'd14718068;
      5'd3:    v = 27'd7471121;
      5'd4:    v = 27'd3750058;
      5'd5:    v = 27'd1876857;
      5'd6:    v = 27'd938658;
      5'd7:    v = 27'd469357;
      5'd8:    v = 27'd234682;
      5'd9:    v = 27'd117342;
      5'd10:   v = 27'd58671;
      5'd11:   v = 27'd29335;
      5'd12:   v = 27'd14668;
      5'd13:   v = 27'd7334;
      5'd14:   v = 27'd3667;
      5'd15:   v = 27'd1833;
      5'd16:   v = 27'd917;
      5'd17:   v = 27'd458;
      5'd18:   v = 27'd229;
      5'd19:   v = 27'd115;
      5'd20:   v = 27'd57;
      5'd21:   v = 27'd29;
      5'd22:   v = 27'd14;
      5'd23:   v = 27'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/ictf_ctrl.sv
// ----------------------------------------------------------------------------
// ictf_ctrl
// Sequencer: steps the datapath through squares, root and divide, CORDIC and
// blend, and owns both handshakes.
// ----------------------------------------------------------------------------
module ictf_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ictf_pkg::ictf_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQUARE, S_SETUP, S_ITER, S_CINIT, S_CORD, S_ROUND, S_MUL, S_COMMIT
  } state_e;

  localparam logic [ictf_pkg::StepW-1:0] LastIter = ictf_pkg::StepW'(ictf_pkg::SqrtSteps - 1);
  localparam logic [ictf_pkg::StepW-1:0] LastCord = ictf_pkg::StepW'(CORDIC_STEPS - 1);

  state_e                      state_q;
  logic [ictf_pkg::StepW-1:0]  cnt_q;
  logic                        out_valid_q;
  logic                        commit_go;

  assign commit_go   = (state_q == S_COMMIT) && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.square = (state_q == S_SQUARE);
    cmd_o.setup  = (state_q == S_SETUP);
    cmd_o.iter   = (state_q == S_ITER);
    cmd_o.cinit  = (state_q == S_CINIT);
    cmd_o.cord   = (state_q == S_CORD);
    cmd_o.round  = (state_q == S_ROUND);
    cmd_o.mul    = (state_q == S_MUL);
    cmd_o.commit = commit_go;
    cmd_o.step   = cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_SQUARE;
        end
        S_SQUARE: state_q <= S_SETUP;
        S_SETUP: begin
          cnt_q   <= '0;
          state_q <= S_ITER;
        end
        S_ITER: begin
          if (cnt_q == LastIter) begin
            state_q <= S_CINIT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_CINIT: begin
          cnt_q   <= '0;
          state_q <= S_CORD;
        end
        S_CORD: begin
          if (cnt_q == LastCord) begin
            state_q <= S_ROUND;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_ROUND:  state_q <= S_MUL;
        S_MUL:    state_q <= S_COMMIT;
        S_COMMIT: begin
          if (commit_go) state_q <= S_IDLE;
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/ictf_dp.sv
// ----------------------------------------------------------------------------
// ictf_dp
// Datapath: squares, bit-serial root, reciprocal gyro divide, vectoring
// CORDIC, blend and the kept angle estimates.
// ----------------------------------------------------------------------------
module ictf_dp #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ictf_pkg::ictf_cmd_t        cmd_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [16:0]                cfg_data_i,
  input  logic signed [15:0]         accel_x_i,
  input  logic signed [15:0]         accel_y_i,
  input  logic signed [15:0]         accel_z_i,
  input  logic signed [15:0]         rate_x_i,
  input  logic signed [15:0]         rate_y_i,
  output logic signed [17:0]         roll_angle_o,
  output logic signed [17:0]         pitch_angle_o
);

  localparam int F   = ANGLE_FRAC_BITS;
  localparam int EW  = F + 10;
  localparam int SW  = EW + 1;
  localparam int PW  = SW + 19;
  localparam int QW  = F + 7;
  localparam int DW  = F + 36;
  localparam int GW  = QW + 34;
  localparam int XW  = QW + 27;
  localparam int RW  = 49;
  localparam int CW  = 27;
  localparam int ZW  = 29;
  localparam int SH  = 20 - F;
  localparam logic signed [EW-1:0] Lim  = EW'(360 * (1 << F));
  localparam logic signed [ZW-1:0] ZRnd = ZW'(1 << (19 - F));
  localparam logic [QW-1:0] GyroRecip =
    QW'((64'd1 << (32 + F)) / 64'(ictf_pkg::GyroDen));
  localparam logic [ictf_pkg::StepW-1:0] DivEst  = ictf_pkg::StepW'(0);
  localparam logic [ictf_pkg::StepW-1:0] DivRem  = ictf_pkg::StepW'(1);
  localparam logic [ictf_pkg::StepW-1:0] DivFix0 = ictf_pkg::StepW'(2);
  localparam logic [ictf_pkg::StepW-1:0] DivFix1 = ictf_pkg::StepW'(3);

  logic [16:0]               weight_q, period_q;
  logic signed [15:0]        ax_q, ay_q, az_q, gx_q, gy_q;
  logic [30:0]               sq_ax_q, sq_ay_q, sq_az_q;
  logic [33:0]               gp_r_q, gp_p_q;
  logic [RW-1:0]             sv_r_q, sv_p_q, sr_r_q, sr_p_q;
  logic [DW-1:0]             nr_r_q, nr_p_q;
  logic [QW-1:0]             q_r_q, q_p_q;
  logic signed [CW-1:0]      x_r_q, y_r_q, x_p_q, y_p_q;
  logic signed [ZW-1:0]      z_r_q, z_p_q;
  logic                      zero_r_q, zero_p_q;
  logic signed [EW-1:0]      acc_r_q, acc_p_q;
  logic signed [SW-1:0]      d_r_q, d_p_q;
  logic signed [PW-1:0]      m1_r_q, m2_r_q, m1_p_q, m2_p_q;
  logic signed [EW-1:0]      roll_est_q, pitch_est_q;

  logic [16:0]               a_c;
  logic [16:0]               mx, my;
  logic [ictf_pkg::StepW-1:0] k;
  logic [RW-1:0]             bitv;
  logic [GW-1:0]             gr_r, gr_p;
  logic [XW-1:0]             qd_r, qd_p;
  logic signed [CW-1:0]      xs_r, ys_r, xs_p, ys_p;
  logic signed [ZW-1:0]      at;
  logic signed [CW-1:0]      y0_r, y0_p;
  logic signed [PW-1:0]      s_r, s_p;
  logic signed [EW-1:0]      c_r, c_p;

  assign a_c  = (weight_q > ictf_pkg::WeightOne) ? ictf_pkg::WeightOne : weight_q;
  assign mx   = gx_q[15] ? 17'(-$signed({gx_q[15], gx_q})) : {1'b0, gx_q};
  assign my   = gy_q[15] ? 17'(-$signed({gy_q[15], gy_q})) : {1'b0, gy_q};
  assign k    = ictf_pkg::StepW'(ictf_pkg::SqrtSteps - 1) - cmd_i.step;
  assign bitv = RW'(1) << {k, 1'b0};
  assign gr_r = GW'(gp_r_q) * GW'(GyroRecip);
  assign gr_p = GW'(gp_p_q) * GW'(GyroRecip);
  assign qd_r = XW'(q_r_q) * XW'(ictf_pkg::GyroDen);
  assign qd_p = XW'(q_p_q) * XW'(ictf_pkg::GyroDen);
  assign xs_r = x_r_q >>> cmd_i.step;
  assign ys_r = y_r_q >>> cmd_i.step;
  assign xs_p = x_p_q >>> cmd_i.step;
  assign ys_p = y_p_q >>> cmd_i.step;
  assign at   = ZW'(ictf_pkg::atan_entry(cmd_i.step));
  assign y0_r = CW'($signed({ay_q[15], ay_q, 8'd0}));
  assign y0_p = CW'(-$signed({ax_q[15], ax_q, 8'd0}));
  assign s_r  = m1_r_q + m2_r_q + PW'(32768);
  assign s_p  = m1_p_q + m2_p_q + PW'(32768);

  function automatic logic signed [EW-1:0] clamp(input logic signed [PW-1:0] s);
    logic signed [PW-1:0] r;
    r = s >>> 16;
    if (r > PW'(Lim)) return Lim;
    if (r < -PW'(Lim)) return -Lim;
    return EW'(r);
  endfunction

  function automatic logic signed [EW-1:0] zround(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] t;
    t = (z + ZRnd) >>> SH;
    return EW'(t);
  endfunction

  assign c_r = clamp(s_r);
  assign c_p = clamp(s_p);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q    <= ictf_pkg::BlendWeightRst;
      period_q    <= ictf_pkg::SamplePeriodRst;
      roll_est_q  <= '0;
      pitch_est_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ictf_pkg::RegBlendWeight:  weight_q <= cfg_data_i;
          ictf_pkg::RegSamplePeriod: period_q <= cfg_data_i;
          default:                   weight_q <= weight_q;
        endcase
      end
      if (cmd_i.commit) begin
        roll_est_q  <= c_r;
        pitch_est_q <= c_p;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q <= accel_x_i;
      ay_q <= accel_y_i;
      az_q <= accel_z_i;
      gx_q <= rate_x_i;
      gy_q <= rate_y_i;
    end
    if (cmd_i.square) begin
      sq_ax_q <= 31'(ax_q) * 31'(ax_q);
      sq_ay_q <= 31'(ay_q) * 31'(ay_q);
      sq_az_q <= 31'(az_q) * 31'(az_q);
      gp_r_q  <= 34'(mx) * 34'(period_q);
      gp_p_q  <= 34'(my) * 34'(period_q);
    end
    if (cmd_i.setup) begin
      sv_r_q <= RW'({32'(sq_ax_q) + 32'(sq_az_q), 16'd0});
      sv_p_q <= RW'({32'(sq_ay_q) + 32'(sq_az_q), 16'd0});
      sr_r_q <= '0;
      sr_p_q <= '0;
      nr_r_q <= (DW'(gp_r_q) << F) + DW'(ictf_pkg::GyroHalfDen);
      nr_p_q <= (DW'(gp_p_q) << F) + DW'(ictf_pkg::GyroHalfDen);
      q_r_q  <= '0;
      q_p_q  <= '0;
    end
    if (cmd_i.iter) begin
      if (sv_r_q >= sr_r_q + bitv) begin
        sv_r_q <= sv_r_q - (sr_r_q + bitv);
        sr_r_q <= (sr_r_q >> 1) + bitv;
      end else begin
        sr_r_q <= sr_r_q >> 1;
      end
      if (sv_p_q >= sr_p_q + bitv) begin
        sv_p_q <= sv_p_q - (sr_p_q + bitv);
        sr_p_q <= (sr_p_q >> 1) + bitv;
      end else begin
        sr_p_q <= sr_p_q >> 1;
      end
      if (cmd_i.step == DivEst) begin
        q_r_q <= gr_r[32 +: QW];
        q_p_q <= gr_p[32 +: QW];
      end else if (cmd_i.step == DivRem) begin
        nr_r_q <= nr_r_q - DW'(qd_r);
        nr_p_q <= nr_p_q - DW'(qd_p);
      end else if (cmd_i.step == DivFix0 || cmd_i.step == DivFix1) begin
        if (nr_r_q >= DW'(ictf_pkg::GyroDen)) begin
          nr_r_q <= nr_r_q - DW'(ictf_pkg::GyroDen);
          q_r_q  <= q_r_q + 1'b1;
        end
        if (nr_p_q >= DW'(ictf_pkg::GyroDen)) begin
          nr_p_q <= nr_p_q - DW'(ictf_pkg::GyroDen);
          q_p_q  <= q_p_q + 1'b1;
        end
      end
    end
    if (cmd_i.cinit) begin
      x_r_q    <= CW'(sr_r_q);
      x_p_q    <= CW'(sr_p_q);
      y_r_q    <= y0_r;
      y_p_q    <= y0_p;
      z_r_q    <= '0;
      z_p_q    <= '0;
      zero_r_q <= (sr_r_q == '0) && (y0_r == '0);
      zero_p_q <= (sr_p_q == '0) && (y0_p == '0);
    end
    if (cmd_i.cord) begin
      if (!y_r_q[CW-1]) begin
        x_r_q <= x_r_q + ys_r;
        y_r_q <= y_r_q - xs_r;
        z_r_q <= z_r_q + at;
      end else begin
        x_r_q <= x_r_q - ys_r;
        y_r_q <= y_r_q + xs_r;
        z_r_q <= z_r_q - at;
      end
      if (!y_p_q[CW-1]) begin
        x_p_q <= x_p_q + ys_p;
        y_p_q <= y_p_q - xs_p;
        z_p_q <= z_p_q + at;
      end else begin
        x_p_q <= x_p_q - ys_p;
        y_p_q <= y_p_q + xs_p;
        z_p_q <= z_p_q - at;
      end
    end
    if (cmd_i.round) begin
      acc_r_q <= zero_r_q ? '0 : zround(z_r_q);
      acc_p_q <= zero_p_q ? '0 : zround(z_p_q);
      d_r_q   <= gx_q[15] ? -$signed(SW'(q_r_q)) : $signed(SW'(q_r_q));
      d_p_q   <= gy_q[15] ? -$signed(SW'(q_p_q)) : $signed(SW'(q_p_q));
    end
    if (cmd_i.mul) begin
      m1_r_q <= PW'($signed({1'b0, a_c})) * PW'(SW'(roll_est_q) + d_r_q);
      m1_p_q <= PW'($signed({1'b0, a_c})) * PW'(SW'(pitch_est_q) + d_p_q);
      m2_r_q <= PW'($signed({1'b0, ictf_pkg::WeightOne - a_c})) * PW'(acc_r_q);
      m2_p_q <= PW'($signed({1'b0, ictf_pkg::WeightOne - a_c})) * PW'(acc_p_q);
    end
  end

  assign roll_angle_o  = 18'(roll_est_q);
  assign pitch_angle_o = 18'(pitch_est_q);

endmodule

>>> rtl/imu_complementary_tilt_filter_unit.sv
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter_unit
// Roll and pitch complementary filter for raw six-axis sensor samples.
// One sample is taken at a time and gives one roll/pitch transaction: the
// sample is squared, then the bit-serial square root runs with the
// reciprocal gyro divide (estimate, remainder and fix-up steps) at its start,
// then the CORDIC iterations, rounding and the blend follow. A new sample is
// taken in the cycle after the result is loaded into the output register,
// which holds it until taken. Angles are signed, in 2^-ANGLE_FRAC_BITS degree,
// clamped to +-360 degrees. Configuration register 0 is the gyro weight
// (fraction of 65536), register 1 the sample period in microseconds.
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter_unit #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] rate_x_i,
  input  logic signed [15:0] rate_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [17:0] roll_angle_o,
  output logic signed [17:0] pitch_angle_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [16:0]        cfg_data_i
);

  ictf_pkg::ictf_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  ictf_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  ictf_dp #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .accel_x_i    (accel_x_i),
    .accel_y_i    (accel_y_i),
    .accel_z_i    (accel_z_i),
    .rate_x_i     (rate_x_i),
    .rate_y_i     (rate_y_i),
    .roll_angle_o (roll_angle_o),
    .pitch_angle_o(pitch_angle_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("sample accepted but sequencer not busy");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o && $past(in_stall_o))
    else $error("result raised without a sample in progress");

  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ANGLE_FRAC_BITS != 8) ||
      (roll_angle_o <= 18'sd92160 && roll_angle_o >= -18'sd92160))
    else $error("roll beyond clamp limit");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ANGLE_FRAC_BITS != 8) ||
      (pitch_angle_o <= 18'sd92160 && pitch_angle_o >= -18'sd92160))
    else $error("pitch beyond clamp limit");

endmodule

>>> tb/tb_imu_complementary_tilt_filter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_imu_complementary_tilt_filter_unit
// Self-checking bench for the roll/pitch complementary filter. Samples are
// queued by the stimulus process, sent by a clocked driver with random gaps,
// and each roll/pitch transaction is checked against a predicted angle pair.
// The weight and sample period are reprogrammed between phases while idle.
// ----------------------------------------------------------------------------
module tb_imu_complementary_tilt_filter_unit;

  localparam int  Steps = 16;
  localparam int  Frac  = 8;
  localparam int  ZFrac = 20;
  localparam longint Lim = 360 <<< Frac;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
  } sample_t;

  typedef struct packed {
    logic signed [17:0] roll;
    logic signed [17:0] pitch;
  } tilt_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] accel_x_i = '0, accel_y_i = '0, accel_z_i = '0;
  logic signed [15:0] rate_x_i = '0, rate_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [17:0] roll_angle_o, pitch_angle_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [16:0] cfg_data_i = '0;

  imu_complementary_tilt_filter_unit #(
    .CORDIC_STEPS(Steps), .ANGLE_FRAC_BITS(Frac)
  ) u_dut (.*);

  always #5 clk_i = ~clk_i;

  sample_t pending_q[$];
  tilt_t   angle_q[$];
  int      mismatches = 0;
  longint  roll_kept = 0, pitch_kept = 0;
  longint  weight = 64225, period_us = 5000;
  int      hold_off = 0;
  bit      big_hold = 0;

  function automatic longint sqrt_floor(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint atan_deg(longint num, longint a, longint b);
    longint x, y, z, xs, ys;
    x = sqrt_floor(longint'((a * a + b * b)) <<< 16);
    y = num * 256;
    z = 0;
    if (x == 0 && y == 0) return 0;
    for (int i = 0; i < Steps && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs;
        z += longint'(ictf_pkg::atan_entry(i[ictf_pkg::StepW-1:0]));
      end else begin
        x -= ys; y += xs;
        z -= longint'(ictf_pkg::atan_entry(i[ictf_pkg::StepW-1:0]));
      end
    end
    z += longint'(1) <<< (ZFrac - Frac - 1);
    return z >>> (ZFrac - Frac);
  endfunction

  function automatic longint rate_delta(longint rate);
    longint mag, q;
    mag = rate < 0 ? -rate : rate;
    q = (((mag * period_us) <<< Frac) + 65500000) / 131000000;
    return rate < 0 ? -q : q;
  endfunction

  function automatic longint fuse(longint est, longint d, longint acc);
    longint a, r;
    a = weight > 65536 ? 65536 : weight;
    r = (a * (est + d) + (65536 - a) * acc + 32768) >>> 16;
    if (r > Lim) r = Lim;
    if (r < -Lim) r = -Lim;
    return r;
  endfunction

  task automatic predict_tilt(sample_t s);
    tilt_t t;
    roll_kept  = fuse(roll_kept, rate_delta(s.gx), atan_deg(s.ay, s.ax, s.az));
    pitch_kept = fuse(pitch_kept, rate_delta(s.gy), atan_deg(-longint'(s.ax), s.ay, s.az));
    t.roll  = roll_kept[17:0];
    t.pitch = pitch_kept[17:0];
    angle_q.push_back(t);
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic int gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      predict_tilt({accel_x_i, accel_y_i, accel_z_i, rate_x_i, rate_y_i});
      void'(pending_q.pop_front());
      in_gap = gap();
    end
    if (!(in_valid_i && in_stall_o)) begin
      if (in_gap > 0 && !(in_valid_i && !in_stall_o && in_gap == 0)) begin
        in_valid_i <= 1'b0;
        in_gap = in_gap - 1;
      end else if (pending_q.size() > 0) begin
        in_valid_i <= 1'b1;
        {accel_x_i, accel_y_i, accel_z_i, rate_x_i, rate_y_i} <= pending_q[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    tilt_t want;
    if (out_valid_o && !out_stall_i) begin
      if (angle_q.size() == 0) begin
        report("unexpected", roll_angle_o, 0);
      end else begin
        want = angle_q.pop_front();
        if (roll_angle_o !== want.roll) report("roll", roll_angle_o, want.roll);
        if (pitch_angle_o !== want.pitch) report("pitch", pitch_angle_o, want.pitch);
      end
    end
    if (big_hold) begin
      out_stall_i <= 1'b1;
      hold_off = 400;
      big_hold = 0;
    end else if (hold_off > 0) begin
      hold_off--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 40) == 0) hold_off = $urandom_range(5, 60);
    end
  end

  task automatic cfg_write(logic idx, logic [16:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == ictf_pkg::RegBlendWeight) weight = val;
    else period_us = val;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || angle_q.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_rand(int n);
    sample_t s;
    for (int i = 0; i < n; i++) begin
      s.ax = pick16(); s.ay = pick16(); s.az = pick16();
      s.gx = pick16(); s.gy = pick16();
      pending_q.push_back(s);
    end
  endtask

  initial begin
    logic [16:0] w_set[5];
    logic [16:0] p_set[5];
    w_set = '{17'd0, 17'd65536, 17'd131071, 17'd32768, 17'd64225};
    p_set = '{17'd1, 17'd100000, 17'd0, 17'd131071, 17'd5000};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    pending_q.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    pending_q.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    pending_q.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
    pending_q.push_back('{16'sd0, 16'sd0, 16'sd16384, -16'sd131, 16'sd131});
    pending_q.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    pending_q.push_back('{16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    pending_q.push_back('{-16'sd32768, 16'sd32767, 16'sd0, 16'sd1, -16'sd1});
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      cfg_write(ictf_pkg::RegBlendWeight, w_set[ph]);
      cfg_write(ictf_pkg::RegSamplePeriod, p_set[ph]);
      pending_q.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sh7fff, -16'sd32768});
      add_rand(200);
      if (ph == 2) begin
        wait (pending_q.size() < 150);
        big_hold = 1;
      end
      drain();
    end
    cfg_write(ictf_pkg::RegBlendWeight, 17'($urandom_range(60000, 65536)));
    cfg_write(ictf_pkg::RegSamplePeriod, 17'($urandom_range(1, 100000)));
    add_rand(600);
    drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
